@@ rtl/core/nnbs_pkg.sv @@
package nnbs_pkg;

  // stream payload widths, padded to whole bytes
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 72;

  // decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic [5:0] HEADER_BYTES = 6'd54;
  localparam logic [7:0] PAD_BYTE     = 8'h00;

  localparam logic FUNC_STEP = 1'b0;
  localparam logic FUNC_FILL = 1'b1;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_PAD   = 2'd1,
    KIND_FETCH = 2'd2,
    KIND_DONE  = 2'd3
  } nnbs_kind_t;

  typedef enum logic [2:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_DEST_WIDTH    = 3'd2,
    REG_DEST_HEIGHT   = 3'd3,
    REG_INVERSE_SCALE = 3'd4
  } nnbs_reg_t;

  // classified request as it travels from front to back
  typedef struct packed {
    logic        fill;
    logic        col_ok;
    logic [11:0] col;
    logic [23:0] pix;
  } nnbs_item_t;

  // queue handshake between the parts
  typedef struct packed {
    logic       valid;
    nnbs_item_t item;
  } nnbs_link_t;

endpackage

@@ rtl/core/nnbs_front.sv @@
module nnbs_front
  import nnbs_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // column[11:0], pixel[35:12], zero fill
  input  logic [0:0]          s_tuser,   // func[0]
  output nnbs_link_t          push,
  input  logic                push_ready
);

  logic       f_valid;
  nnbs_item_t f_item;
  nnbs_item_t item_next;
  logic       load;

  // classify: fill or step, and whether a fill lands inside the buffer
  always_comb begin
    item_next.fill   = (s_tuser[0] == FUNC_FILL);
    item_next.col    = s_tdata[11:0];
    item_next.pix    = s_tdata[35:12];
    item_next.col_ok = ({20'd0, s_tdata[11:0]} < 32'(MAX_SOURCE_WIDTH));
  end

  assign s_tready = !f_valid || push_ready;
  assign load     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (load) begin
      f_valid <= 1'b1;
    end else if (push_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      f_item <= item_next;
    end
  end

  assign push.valid = f_valid;
  assign push.item  = f_item;

endmodule

@@ rtl/core/nnbs_queue.sv @@
module nnbs_queue
  import nnbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  nnbs_link_t push,
  output logic       push_ready,
  output nnbs_link_t head,
  input  logic       pop
);

  nnbs_item_t          slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.item;
    end
  end

endmodule

@@ rtl/core/nnbs_back.sv @@
module nnbs_back
  import nnbs_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  nnbs_link_t  head,
  output logic        pop,
  output logic        res_valid,
  input  logic        res_ready,
  output nnbs_kind_t  res_kind,
  output logic [23:0] res_pixel,
  output logic [15:0] res_row,
  output logic [29:0] res_offset,
  output logic        res_last
);

  localparam int AW = (MAX_SOURCE_WIDTH > 1) ? $clog2(MAX_SOURCE_WIDTH) : 1;
  localparam logic [16:0] MAX_W = 17'(MAX_SOURCE_WIDTH);

  // configuration
  logic [12:0] source_width;
  logic [15:0] source_height;
  logic [15:0] dest_width;
  logic [15:0] dest_height;
  logic [31:0] inverse_scale;

  // raster state
  logic [15:0] out_x, out_x_next;
  logic [15:0] out_y, out_y_next;
  logic [1:0]  pad_left, pad_left_next;
  logic [15:0] loaded_row, loaded_row_next;
  logic        row_valid, row_valid_next;
  logic [47:0] col_acc, col_acc_next;
  logic [47:0] row_acc, row_acc_next;
  logic        frame_done, frame_done_next;

  // line buffer
  logic [23:0] line_mem [MAX_SOURCE_WIDTH];
  logic [23:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0] col_ext;
  logic        mem_we;

  // stage B: decision taken, buffer read in flight
  logic        b_valid;
  nnbs_kind_t  b_kind;
  logic [15:0] b_row;
  logic        b_last;
  logic        b_load;
  logic        b_free;
  logic        c_load;

  // decision signals
  nnbs_kind_t  a_kind;
  logic [15:0] a_row;
  logic        a_last;
  logic        end_row;
  logic [12:0] sw1;
  logic [15:0] sh1, dw1, dh1;
  logic [16:0] sw1_ext, cmax;
  logic [15:0] src_row, src_col, x_inc, y_inc;
  logic [1:0]  pad_dec;
  logic [14:0] stride;
  logic [30:0] prod;

  assign sw1 = (source_width == '0)  ? 13'd1 : source_width;
  assign sh1 = (source_height == '0) ? 16'd1 : source_height;
  assign dw1 = (dest_width == '0)    ? 16'd1 : dest_width;
  assign dh1 = (dest_height == '0)   ? 16'd1 : dest_height;

  assign sw1_ext = {4'd0, sw1};
  assign cmax    = ((sw1_ext > MAX_W) ? MAX_W : sw1_ext) - 17'd1;

  assign src_row = (row_acc[47:16] > {16'd0, sh1 - 16'd1}) ? (sh1 - 16'd1) : row_acc[31:16];
  assign src_col = (col_acc[47:16] > {15'd0, cmax}) ? cmax[15:0] : col_acc[31:16];
  assign rd_addr = src_col[AW-1:0];

  assign col_ext = {20'd0, head.item.col};
  assign wr_addr = col_ext[AW-1:0];

  assign c_load = b_valid && (!res_valid || res_ready);
  assign b_free = !b_valid || c_load;

  always_comb begin
    pop             = 1'b0;
    mem_we          = 1'b0;
    b_load          = 1'b0;
    a_kind          = KIND_DONE;
    a_row           = '0;
    a_last          = 1'b0;
    end_row         = 1'b0;
    x_inc           = out_x + 16'd1;
    y_inc           = out_y + 16'd1;
    pad_dec         = (pad_left != '0) ? pad_left - 2'd1 : 2'd0;
    out_x_next      = out_x;
    out_y_next      = out_y;
    pad_left_next   = pad_left;
    loaded_row_next = loaded_row;
    row_valid_next  = row_valid;
    col_acc_next    = col_acc;
    row_acc_next    = row_acc;
    frame_done_next = frame_done;

    if (head.valid) begin
      if (head.item.fill) begin
        // fills never wait on the result side
        pop    = 1'b1;
        mem_we = head.item.col_ok;
      end else if (b_free) begin
        pop    = 1'b1;
        b_load = 1'b1;
        if (frame_done) begin
          a_kind = KIND_DONE;
        end else if (!row_valid || loaded_row != src_row) begin
          a_kind          = KIND_FETCH;
          a_row           = src_row;
          loaded_row_next = src_row;
          row_valid_next  = 1'b1;
        end else if (out_x < dw1) begin
          a_kind       = KIND_PIXEL;
          out_x_next   = x_inc;
          col_acc_next = col_acc + {16'd0, inverse_scale};
          if (x_inc >= dw1) begin
            pad_left_next = dw1[1:0];
            end_row       = (dw1[1:0] == 2'd0);
          end
        end else begin
          a_kind        = KIND_PAD;
          pad_left_next = pad_dec;
          end_row       = (pad_dec == 2'd0);
        end

        if (end_row) begin
          out_x_next    = '0;
          pad_left_next = '0;
          col_acc_next  = '0;
          out_y_next    = y_inc;
          row_acc_next  = row_acc + {16'd0, inverse_scale};
          if (y_inc >= dh1) begin
            frame_done_next = 1'b1;
            a_last          = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= 13'd1;
      source_height <= 16'd1;
      dest_width    <= 16'd1;
      dest_height   <= 16'd1;
      inverse_scale <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[12:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[15:0];
        REG_DEST_WIDTH:    dest_width    <= cfg_data[15:0];
        REG_DEST_HEIGHT:   dest_height   <= cfg_data[15:0];
        REG_INVERSE_SCALE: inverse_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_x      <= '0;
      out_y      <= '0;
      pad_left   <= '0;
      loaded_row <= '0;
      row_valid  <= 1'b0;
      col_acc    <= '0;
      row_acc    <= '0;
      frame_done <= 1'b0;
    end else begin
      out_x      <= out_x_next;
      out_y      <= out_y_next;
      pad_left   <= pad_left_next;
      loaded_row <= loaded_row_next;
      row_valid  <= row_valid_next;
      col_acc    <= col_acc_next;
      row_acc    <= row_acc_next;
      frame_done <= frame_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[wr_addr] <= head.item.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      rd_data <= line_mem[rd_addr];
    end
  end

  // stage B control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= 1'b1;
    end else if (c_load) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_kind <= a_kind;
      b_row  <= a_row;
      b_last <= a_last;
    end
  end

  // stage C: offset multiply and output register
  assign stride = {2'b00, source_width} + {1'b0, source_width, 1'b0}
                + {13'd0, source_width[1:0]};
  assign prod   = {16'd0, stride} * {15'd0, b_row};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (c_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      res_kind   <= b_kind;
      res_pixel  <= (b_kind == KIND_PIXEL) ? rd_data : {16'd0, PAD_BYTE};
      res_row    <= (b_kind == KIND_FETCH) ? b_row : 16'd0;
      res_offset <= (b_kind == KIND_FETCH) ? 30'(prod + {25'd0, HEADER_BYTES}) : 30'd0;
      res_last   <= b_last;
    end
  end

  // a finished frame stays finished until reset
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    frame_done |=> frame_done)
    else $error("frame complete flag dropped");

  // padding only follows a completed pixel run
  a_pad_after_run: assert property (@(posedge clk) disable iff (rst)
    (pad_left != 2'd0) |-> (out_x != 16'd0))
    else $error("padding pending at start of row");

  // a stalled stage B must keep its request
  a_b_holds: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !c_load) |=> (b_valid && $stable(b_kind) && $stable(b_row)))
    else $error("stage B request lost under stall");

  // fetch requests never close a frame
  a_fetch_not_last: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_kind == KIND_FETCH) |-> !b_last)
    else $error("fetch marked as frame end");

endmodule

@@ rtl/core/nearest_neighbor_bitmap_scaler_core.sv @@
// Nearest-neighbour scaler core for 24-bit bottom-up raster scanlines.
//
// Input stream (s_*): each request is a fill (tuser = 1), writing one RGB
// pixel into the source line buffer at the given column, or a step
// (tuser = 0), advancing the output raster. Fills give no result; every
// step gives exactly one result on the output stream (m_*): a fetch row
// request with the row's file offset, an output pixel, a zero padding
// byte, or frame complete. tlast marks the pixel or pad ending the frame.
// Configuration registers are written over cfg_we/cfg_index/cfg_data
// while the core is idle; they take effect at once.
//
// Throughput: one request per clock, fills and steps alike, while the
// queue has room; a step also waits while stage B is held by a stall.
// An accepted step passes the input register, the queue, the decision
// plus line buffer read, and the offset multiply and output register.
// A stall on m_tready holds the output register; the queue between the
// front and the back keeps the input side running until it fills.
// Reset (rst, synchronous) restores register defaults, empties the queue
// and restarts the raster; the line buffer contents are left as they are.
module nearest_neighbor_bitmap_scaler_core
  import nnbs_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  // request stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // column[11:0], pixel[35:12], zero fill
  input  logic [0:0]          s_tuser,   // func[0]
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // out_pixel[23:0], fetch_row[39:24],
                                         // fetch_offset[69:40], zero fill
  output logic [1:0]          m_tuser,   // kind[1:0]
  output logic                m_tlast    // frame_last
);

  nnbs_link_t  push;
  nnbs_link_t  head;
  logic        push_ready;
  logic        pop;
  nnbs_kind_t  res_kind;
  logic [23:0] res_pixel;
  logic [15:0] res_row;
  logic [29:0] res_offset;

  // front: accepts and classifies requests
  nnbs_front #(
    .MAX_SOURCE_WIDTH(MAX_SOURCE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_ready(push_ready)
  );

  // short queue decoupling the two sides
  nnbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ready(push_ready),
    .head      (head),
    .pop       (pop)
  );

  // back: raster state, line buffer and result pipeline
  nnbs_back #(
    .MAX_SOURCE_WIDTH(MAX_SOURCE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_kind  (res_kind),
    .res_pixel (res_pixel),
    .res_row   (res_row),
    .res_offset(res_offset),
    .res_last  (m_tlast)
  );

  assign m_tdata = {2'b00, res_offset, res_row, res_pixel};
  assign m_tuser = res_kind;

endmodule
